[hdl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and reset
`define CPIP_ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cpip assertion failed");

// concurrent check on the module clock and reset
`define CPIP_ASSERT(label, prop) \
   `CPIP_ASSERT_CLK(label, clock, reset, prop)

`endif

[hdl/cpip_pkg.sv]
// shared constants and types for the circle pair intersection block
`timescale 1ns / 1ps

package cpip_pkg;

   // width of every point coordinate, signed fixed point
   localparam int PT_BITS = 33;

   typedef enum logic [1:0] {
      STATUS_TWO     = 2'd0,
      STATUS_TANGENT = 2'd1,
      STATUS_NONE    = 2'd2,
      STATUS_SAME    = 2'd3
   } status_type;

endpackage

[hdl/cpip_if.sv]
// valid/ready channel interfaces for circle pairs and intersection points
`timescale 1ns / 1ps

interface cpip_req_if #(parameter int COORD_BITS = 16) (input logic clock);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] first_center_x;
   logic signed [COORD_BITS-1:0] first_center_y;
   logic        [COORD_BITS-2:0] first_radius;
   logic signed [COORD_BITS-1:0] second_center_x;
   logic signed [COORD_BITS-1:0] second_center_y;
   logic        [COORD_BITS-2:0] second_radius;

   modport source (
      input  clock, ready,
      output valid, first_center_x, first_center_y, first_radius,
             second_center_x, second_center_y, second_radius
   );
   modport sink (
      input  clock, valid, first_center_x, first_center_y, first_radius,
             second_center_x, second_center_y, second_radius,
      output ready
   );
endinterface

interface cpip_rsp_if (input logic clock);
   import cpip_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [PT_BITS-1:0] point_a_x;
   logic signed [PT_BITS-1:0] point_a_y;
   logic signed [PT_BITS-1:0] point_b_x;
   logic signed [PT_BITS-1:0] point_b_y;
   status_type                status;

   modport source (
      input  clock, ready,
      output valid, point_a_x, point_a_y, point_b_x, point_b_y, status
   );
   modport sink (
      input  clock, valid, point_a_x, point_a_y, point_b_x, point_b_y, status,
      output ready
   );
endinterface

[hdl/cpip_sqrt_cell.sv]
// one root bit of the pipelined digit-by-digit integer square root
`timescale 1ns / 1ps

module cpip_sqrt_cell #(
   parameter int ROOT_BITS = 48
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [ROOT_BITS+1:0]   up_rem,
   input  logic [ROOT_BITS-1:0]   up_root,
   input  logic [2*ROOT_BITS-1:0] up_rad,
   output logic [ROOT_BITS+1:0]   dn_rem,
   output logic [ROOT_BITS-1:0]   dn_root,
   output logic [2*ROOT_BITS-1:0] dn_rad
);
   logic [ROOT_BITS+3:0]   x;
   logic [ROOT_BITS+3:0]   trial;
   logic                   ge;
   logic [ROOT_BITS+1:0]   rem_in, rem_ff;
   logic [ROOT_BITS-1:0]   root_in, root_ff;
   logic [2*ROOT_BITS-1:0] rad_in, rad_ff;

   // bring down the next two radicand bits, try root*4+1
   always_comb begin
      x       = {up_rem, up_rad[2*ROOT_BITS-1 -: 2]};
      trial   = (ROOT_BITS+4)'({up_root, 2'b01});
      ge      = (x >= trial);
      rem_in  = (ROOT_BITS+2)'(ge ? x - trial : x);
      root_in = {up_root[ROOT_BITS-2:0], ge};
      rad_in  = {up_rad[2*ROOT_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_rad  = rad_ff;
endmodule

[hdl/cpip_div_cell.sv]
// one quotient bit of the pipelined restoring divider
`timescale 1ns / 1ps

module cpip_div_cell #(
   parameter int DIV_BITS = 34,
   parameter int QUO_BITS = 33
) (
   input  logic                clock,
   input  logic                advance,
   input  logic [DIV_BITS-1:0] up_rem,
   input  logic [QUO_BITS-1:0] up_lq,
   input  logic [DIV_BITS-1:0] divisor,
   output logic [DIV_BITS-1:0] dn_rem,
   output logic [QUO_BITS-1:0] dn_lq
);
   logic [DIV_BITS:0]   x;
   logic [DIV_BITS:0]   d_ext;
   logic                ge;
   logic [DIV_BITS-1:0] rem_in, rem_ff;
   logic [QUO_BITS-1:0] lq_in, lq_ff;

   // low numerator bits shift out the top, quotient bits shift in below
   always_comb begin
      x      = {up_rem, up_lq[QUO_BITS-1]};
      d_ext  = (DIV_BITS+1)'(divisor);
      ge     = (x >= d_ext);
      rem_in = DIV_BITS'(ge ? x - d_ext : x);
      lq_in  = {up_lq[QUO_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         lq_ff  <= lq_in;
      end
   end

   assign dn_rem = rem_ff;
   assign dn_lq  = lq_ff;
endmodule

[hdl/circle_pair_intersection_points_top.sv]
// circle pair intersection: a fixed pipeline around a square root chain and a divider chain
// Takes two circles (integer centers, integer radii) and returns the two
// points where they cross, as signed fixed point with FRAC_BITS fraction bits
// in 33-bit fields, plus a status: two points, tangent (both points are the
// touching point), no intersection or same center (points zero for the last
// two). One pair is taken in every cycle while the pipeline is not held. The
// pipeline is made of four front stages, one square root cell per root bit,
// three numerator stages, one divider cell per quotient bit and the output
// register. The whole pipeline moves as one; it holds only while a result
// waits on the output register, and then req.ready is low.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circle_pair_intersection_points_top #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   cpip_req_if.sink  req,
   cpip_rsp_if.source rsp
);
   import cpip_pkg::*;

   localparam int CW    = COORD_BITS;
   localparam int RW    = COORD_BITS - 1;
   localparam int SW    = 2 * COORD_BITS;        // squares of radii
   localparam int TW    = 2 * COORD_BITS + 1;    // squared center distance
   localparam int A2W   = 2 * COORD_BITS + 2;    // |2a|
   localparam int PMW   = 4 * COORD_BITS;        // (sum2 - t) * (t - dif2)
   localparam int SQ    = 2 * COORD_BITS + FRAC_BITS;  // root bits
   localparam int RADW  = 2 * SQ;
   localparam int RMW   = SQ + 2;
   localparam int AMW   = A2W + COORD_BITS;      // |2a| * |q|
   localparam int NW    = 3 * COORD_BITS + FRAC_BITS + 3;  // numerators
   localparam int DW    = 2 * COORD_BITS + 2;    // divisor 2t
   localparam int QB    = COORD_BITS + FRAC_BITS + 1;  // quotient bits
   localparam int LANES = 4;
   localparam int SBW   = 2 + 3 + TW + 4 * CW + 2 * AMW;
   localparam int DBW   = 2 + LANES + 2 * CW;

   // the whole pipeline steps unless a result sits unclaimed
   logic adv;
   logic out_valid_ff;

   assign adv       = !out_valid_ff || rsp.ready;
   assign req.ready = adv;

   // stage 1: center difference as sign and magnitude
   logic signed [CW:0] dx_in, dy_in;
   logic               s1_valid_ff;
   logic [CW-1:0]      s1_mx_ff, s1_my_ff;
   logic               s1_sx_ff, s1_sy_ff;
   logic [RW-1:0]      s1_r1_ff, s1_r2_ff;
   logic signed [CW-1:0] s1_x2_ff, s1_y2_ff;

   always_comb begin
      dx_in = (CW+1)'(req.first_center_x) - (CW+1)'(req.second_center_x);
      dy_in = (CW+1)'(req.first_center_y) - (CW+1)'(req.second_center_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sx_ff <= dx_in[CW];
         s1_sy_ff <= dy_in[CW];
         s1_mx_ff <= CW'(dx_in[CW] ? -dx_in : dx_in);
         s1_my_ff <= CW'(dy_in[CW] ? -dy_in : dy_in);
         s1_r1_ff <= req.first_radius;
         s1_r2_ff <= req.second_radius;
         s1_x2_ff <= req.second_center_x;
         s1_y2_ff <= req.second_center_y;
      end
   end

   // stage 2: squares
   logic [SW-1:0] mxsq, mysq, sum2_in, dif2_in, r1sq_in, r2sq_in;
   logic [CW-1:0] rsum;
   logic [RW-1:0] rdif;
   logic          s2_valid_ff;
   logic [TW-1:0] s2_t_ff;
   logic [SW-1:0] s2_sum2_ff, s2_dif2_ff, s2_r1sq_ff, s2_r2sq_ff;
   logic [CW-1:0] s2_mx_ff, s2_my_ff;
   logic          s2_sx_ff, s2_sy_ff;
   logic signed [CW-1:0] s2_x2_ff, s2_y2_ff;

   always_comb begin
      mxsq    = SW'(s1_mx_ff) * SW'(s1_mx_ff);
      mysq    = SW'(s1_my_ff) * SW'(s1_my_ff);
      rsum    = CW'(s1_r1_ff) + CW'(s1_r2_ff);
      rdif    = (s1_r1_ff >= s1_r2_ff) ? s1_r1_ff - s1_r2_ff : s1_r2_ff - s1_r1_ff;
      sum2_in = SW'(rsum) * SW'(rsum);
      dif2_in = SW'(rdif) * SW'(rdif);
      r1sq_in = SW'(s1_r1_ff) * SW'(s1_r1_ff);
      r2sq_in = SW'(s1_r2_ff) * SW'(s1_r2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_t_ff    <= TW'(mxsq) + TW'(mysq);
         s2_sum2_ff <= sum2_in;
         s2_dif2_ff <= dif2_in;
         s2_r1sq_ff <= r1sq_in;
         s2_r2sq_ff <= r2sq_in;
         s2_mx_ff   <= s1_mx_ff;
         s2_my_ff   <= s1_my_ff;
         s2_sx_ff   <= s1_sx_ff;
         s2_sy_ff   <= s1_sy_ff;
         s2_x2_ff   <= s1_x2_ff;
         s2_y2_ff   <= s1_y2_ff;
      end
   end

   // stage 3: classify, sqrt factors and |2a| with its sign
   logic [A2W-1:0] big, r1w;
   logic [TW-1:0]  p_in, m_in;
   logic [1:0]     status_in;
   logic           s3_valid_ff;
   logic [1:0]     s3_status_ff;
   logic [TW-1:0]  s3_t_ff, s3_p_ff, s3_m_ff;
   logic [A2W-1:0] s3_a2_ff;
   logic           s3_sa_ff;
   logic [CW-1:0]  s3_mx_ff, s3_my_ff;
   logic           s3_sx_ff, s3_sy_ff;
   logic signed [CW-1:0] s3_x2_ff, s3_y2_ff;

   always_comb begin
      big  = A2W'(s2_t_ff) + A2W'(s2_r2sq_ff);
      r1w  = A2W'(s2_r1sq_ff);
      p_in = TW'(s2_sum2_ff) - s2_t_ff;
      m_in = s2_t_ff - TW'(s2_dif2_ff);
      if (s2_t_ff == '0) begin
         status_in = STATUS_SAME;
      end else if (s2_t_ff > TW'(s2_sum2_ff) || s2_t_ff < TW'(s2_dif2_ff)) begin
         status_in = STATUS_NONE;
      end else if (p_in == '0 || m_in == '0) begin
         status_in = STATUS_TANGENT;
      end else begin
         status_in = STATUS_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_status_ff <= status_in;
         s3_t_ff      <= s2_t_ff;
         s3_p_ff      <= p_in;
         s3_m_ff      <= m_in;
         s3_sa_ff     <= (big < r1w);
         s3_a2_ff     <= (big < r1w) ? r1w - big : big - r1w;
         s3_mx_ff     <= s2_mx_ff;
         s3_my_ff     <= s2_my_ff;
         s3_sx_ff     <= s2_sx_ff;
         s3_sy_ff     <= s2_sy_ff;
         s3_x2_ff     <= s2_x2_ff;
         s3_y2_ff     <= s2_y2_ff;
      end
   end

   // stage 4: radicand product and the |2a|*|q| terms
   logic [2*TW-1:0] pm_full;
   logic [AMW-1:0]  t1raw_in, t3raw_in;
   logic            s4_valid_ff;
   logic [PMW-1:0]  s4_pm_ff;
   logic [SBW-1:0]  s4_sb;
   logic [1:0]      s4_status_ff;
   logic [TW-1:0]   s4_t_ff;
   logic            s4_sa_ff, s4_sx_ff, s4_sy_ff;
   logic [CW-1:0]   s4_mx_ff, s4_my_ff;
   logic signed [CW-1:0] s4_x2_ff, s4_y2_ff;
   logic [AMW-1:0]  s4_t1_ff, s4_t3_ff;

   always_comb begin
      pm_full  = (2*TW)'(s3_p_ff) * (2*TW)'(s3_m_ff);
      t1raw_in = AMW'(s3_a2_ff) * AMW'(s3_mx_ff);
      t3raw_in = AMW'(s3_a2_ff) * AMW'(s3_my_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_pm_ff     <= pm_full[PMW-1:0];
         s4_t1_ff     <= t1raw_in;
         s4_t3_ff     <= t3raw_in;
         s4_status_ff <= s3_status_ff;
         s4_t_ff      <= s3_t_ff;
         s4_sa_ff     <= s3_sa_ff;
         s4_sx_ff     <= s3_sx_ff;
         s4_sy_ff     <= s3_sy_ff;
         s4_mx_ff     <= s3_mx_ff;
         s4_my_ff     <= s3_my_ff;
         s4_x2_ff     <= s3_x2_ff;
         s4_y2_ff     <= s3_y2_ff;
      end
   end

   // everything the square root chain carries alongside the root
   assign s4_sb = {s4_status_ff, s4_sa_ff, s4_sx_ff, s4_sy_ff, s4_t_ff,
                   s4_x2_ff, s4_y2_ff, s4_mx_ff, s4_my_ff, s4_t1_ff, s4_t3_ff};

   // square root chain: floor(sqrt(pm * 2^(2*FRAC_BITS))), one root bit per cell
   logic [RMW-1:0]  sq_rem  [SQ];
   logic [SQ-1:0]   sq_root [SQ];
   logic [RADW-1:0] sq_rad  [SQ];
   logic            sq_valid_ff [SQ];
   logic [SBW-1:0]  sq_sb_ff    [SQ];

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      logic [RMW-1:0]  rem_up;
      logic [SQ-1:0]   root_up;
      logic [RADW-1:0] rad_up;
      logic            valid_up;
      logic [SBW-1:0]  sb_up;

      if (k == 0) begin : g_head
         assign rem_up   = '0;
         assign root_up  = '0;
         assign rad_up   = {s4_pm_ff, {(2*FRAC_BITS){1'b0}}};
         assign valid_up = s4_valid_ff;
         assign sb_up    = s4_sb;
      end else begin : g_link
         assign rem_up   = sq_rem[k-1];
         assign root_up  = sq_root[k-1];
         assign rad_up   = sq_rad[k-1];
         assign valid_up = sq_valid_ff[k-1];
         assign sb_up    = sq_sb_ff[k-1];
      end

      cpip_sqrt_cell #(
         .ROOT_BITS (SQ)
      ) u_cell (
         .clock   (clock),
         .advance (adv),
         .up_rem  (rem_up),
         .up_root (root_up),
         .up_rad  (rad_up),
         .dn_rem  (sq_rem[k]),
         .dn_root (sq_root[k]),
         .dn_rad  (sq_rad[k])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k] <= valid_up;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_sb_ff[k] <= sb_up;
         end
      end
   end

   // unpack at the root chain exit
   logic [1:0]      e_status;
   logic [TW-1:0]   e_t;
   logic            e_sa, e_sx, e_sy;
   logic [CW-1:0]   e_mx, e_my;
   logic signed [CW-1:0] e_x2, e_y2;
   logic [AMW-1:0]  e_t1, e_t3;
   logic [SQ-1:0]   e_rr;

   assign {e_status, e_sa, e_sx, e_sy, e_t, e_x2, e_y2, e_mx, e_my, e_t1, e_t3} =
      sq_sb_ff[SQ-1];
   assign e_rr = sq_root[SQ-1];

   // stage 5: cross terms |q|*root and the scaled |2a|*|q| terms
   logic [CW+SQ-1:0] t2_in, t4_in;
   logic             s5_valid_ff;
   logic [1:0]       s5_status_ff;
   logic [TW-1:0]    s5_t_ff;
   logic [NW-1:0]    s5_t1_ff, s5_t3_ff;
   logic [CW+SQ-1:0] s5_t2_ff, s5_t4_ff;
   logic             s5_ax_ff, s5_ay_ff, s5_sx_ff, s5_sy_ff;
   logic signed [CW-1:0] s5_x2_ff, s5_y2_ff;

   always_comb begin
      t2_in = (CW+SQ)'(e_my) * (CW+SQ)'(e_rr);
      t4_in = (CW+SQ)'(e_mx) * (CW+SQ)'(e_rr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s5_valid_ff <= sq_valid_ff[SQ-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_status_ff <= e_status;
         s5_t_ff      <= e_t;
         s5_t1_ff     <= NW'(e_t1) << FRAC_BITS;
         s5_t3_ff     <= NW'(e_t3) << FRAC_BITS;
         s5_t2_ff     <= t2_in;
         s5_t4_ff     <= t4_in;
         s5_ax_ff     <= e_sa ^ e_sx;
         s5_ay_ff     <= e_sa ^ e_sy;
         s5_sx_ff     <= e_sx;
         s5_sy_ff     <= e_sy;
         s5_x2_ff     <= e_x2;
         s5_y2_ff     <= e_y2;
      end
   end

   // stage 6: sign-magnitude sums, lanes a.x, a.y, b.x, b.y
   logic [NW-1:0] u [LANES];
   logic [NW-1:0] v [LANES];
   logic          un [LANES];
   logic          vn [LANES];
   logic [NW-1:0] mag_in [LANES];
   logic          neg_in [LANES];
   logic          s6_valid_ff;
   logic [1:0]    s6_status_ff;
   logic [TW-1:0] s6_t_ff;
   logic [NW-1:0] s6_mag_ff [LANES];
   logic          s6_neg_ff [LANES];
   logic signed [CW-1:0] s6_x2_ff, s6_y2_ff;

   always_comb begin
      u[0] = s5_t1_ff; un[0] = s5_ax_ff; v[0] = NW'(s5_t2_ff); vn[0] = s5_sy_ff;
      u[1] = s5_t3_ff; un[1] = s5_ay_ff; v[1] = NW'(s5_t4_ff); vn[1] = !s5_sx_ff;
      u[2] = s5_t1_ff; un[2] = s5_ax_ff; v[2] = NW'(s5_t2_ff); vn[2] = !s5_sy_ff;
      u[3] = s5_t3_ff; un[3] = s5_ay_ff; v[3] = NW'(s5_t4_ff); vn[3] = s5_sx_ff;
      for (int l = 0; l < LANES; l++) begin
         if (un[l] == vn[l]) begin
            mag_in[l] = u[l] + v[l];
            neg_in[l] = un[l];
         end else if (u[l] >= v[l]) begin
            mag_in[l] = u[l] - v[l];
            neg_in[l] = un[l];
         end else begin
            mag_in[l] = v[l] - u[l];
            neg_in[l] = vn[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (adv) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_status_ff <= s5_status_ff;
         s6_t_ff      <= s5_t_ff;
         s6_x2_ff     <= s5_x2_ff;
         s6_y2_ff     <= s5_y2_ff;
         for (int l = 0; l < LANES; l++) begin
            s6_mag_ff[l] <= mag_in[l];
            s6_neg_ff[l] <= neg_in[l];
         end
      end
   end

   // stage 7: add t so the division by 2t rounds half away from zero
   logic          s7_valid_ff;
   logic [DBW-1:0] s7_sb;
   logic [1:0]    s7_status_ff;
   logic [DW-1:0] s7_d_ff;
   logic [NW-1:0] s7_num_ff [LANES];
   logic [LANES-1:0] s7_neg_ff;
   logic signed [CW-1:0] s7_x2_ff, s7_y2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (adv) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_status_ff <= s6_status_ff;
         s7_d_ff      <= DW'(s6_t_ff) << 1;
         s7_x2_ff     <= s6_x2_ff;
         s7_y2_ff     <= s6_y2_ff;
         for (int l = 0; l < LANES; l++) begin
            s7_num_ff[l] <= s6_mag_ff[l] + NW'(s6_t_ff);
            s7_neg_ff[l] <= s6_neg_ff[l];
         end
      end
   end

   assign s7_sb = {s7_status_ff, s7_neg_ff, s7_x2_ff, s7_y2_ff};

   // divider chain: one quotient bit per cell, four lanes side by side
   logic [DW-1:0]  dv_rem [LANES][QB];
   logic [QB-1:0]  dv_lq  [LANES][QB];
   logic           db_valid_ff [QB];
   logic [DBW-1:0] db_sb_ff    [QB];
   logic [DW-1:0]  db_d_ff     [QB];

   for (genvar k = 0; k < QB; k++) begin : g_div
      logic           valid_up;
      logic [DBW-1:0] sb_up;
      logic [DW-1:0]  d_up;

      if (k == 0) begin : g_head
         assign valid_up = s7_valid_ff;
         assign sb_up    = s7_sb;
         assign d_up     = s7_d_ff;
      end else begin : g_link
         assign valid_up = db_valid_ff[k-1];
         assign sb_up    = db_sb_ff[k-1];
         assign d_up     = db_d_ff[k-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DW-1:0] rem_up;
         logic [QB-1:0] lq_up;

         if (k == 0) begin : g_head
            assign rem_up = s7_num_ff[l][NW-1:QB];
            assign lq_up  = s7_num_ff[l][QB-1:0];
         end else begin : g_link
            assign rem_up = dv_rem[l][k-1];
            assign lq_up  = dv_lq[l][k-1];
         end

         cpip_div_cell #(
            .DIV_BITS (DW),
            .QUO_BITS (QB)
         ) u_cell (
            .clock   (clock),
            .advance (adv),
            .up_rem  (rem_up),
            .up_lq   (lq_up),
            .divisor (d_up),
            .dn_rem  (dv_rem[l][k]),
            .dn_lq   (dv_lq[l][k])
         );
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            db_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            db_valid_ff[k] <= valid_up;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            db_sb_ff[k] <= sb_up;
            db_d_ff[k]  <= d_up;
         end
      end
   end

   // output stage: center plus or minus the rounded offset, wrapped to 33 bits
   logic [1:0]        f_status;
   logic [LANES-1:0]  f_neg;
   logic signed [CW-1:0] f_x2, f_y2;
   logic signed [PT_BITS-1:0] f_ctr [LANES];
   logic [PT_BITS-1:0] f_q   [LANES];
   logic [PT_BITS-1:0] pt_in [LANES];
   logic [PT_BITS-1:0] out_pt_ff [LANES];
   logic [1:0]         out_status_ff;

   assign {f_status, f_neg, f_x2, f_y2} = db_sb_ff[QB-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         f_ctr[l] = (l % 2 == 0) ? PT_BITS'(f_x2) : PT_BITS'(f_y2);
         f_q[l]   = PT_BITS'(dv_lq[l][QB-1]);
         if (f_status == STATUS_NONE || f_status == STATUS_SAME) begin
            pt_in[l] = '0;
         end else if (f_neg[l]) begin
            pt_in[l] = (f_ctr[l] <<< FRAC_BITS) - f_q[l];
         end else begin
            pt_in[l] = (f_ctr[l] <<< FRAC_BITS) + f_q[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= db_valid_ff[QB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_status_ff <= f_status;
         for (int l = 0; l < LANES; l++) begin
            out_pt_ff[l] <= pt_in[l];
         end
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.point_a_x = out_pt_ff[0];
   assign rsp.point_a_y = out_pt_ff[1];
   assign rsp.point_b_x = out_pt_ff[2];
   assign rsp.point_b_y = out_pt_ff[3];
   assign rsp.status    = status_type'(out_status_ff);

   // shorthand for the checks below
   logic rsp_no_points;
   logic rsp_points_zero;
   logic rsp_points_same;

   assign rsp_no_points   = rsp.status == STATUS_NONE || rsp.status == STATUS_SAME;
   assign rsp_points_zero = rsp.point_a_x == '0 && rsp.point_a_y == '0 &&
                            rsp.point_b_x == '0 && rsp.point_b_y == '0;
   assign rsp_points_same = rsp.point_a_x == rsp.point_b_x &&
                            rsp.point_a_y == rsp.point_b_y;

   // a result left waiting freezes the pipeline and blocks new pairs
   `CPIP_ASSERT(a_stall_blocks_req, rsp.valid && !rsp.ready |-> !req.ready)
   // no points are reported when the circles do not cross
   `CPIP_ASSERT(a_empty_points_zero, rsp.valid && rsp_no_points |-> rsp_points_zero)
   // tangent circles give one touching point twice
   `CPIP_ASSERT(a_tangent_one_point, rsp.valid && rsp.status == STATUS_TANGENT |-> rsp_points_same)
endmodule

[test/cpip_points_checker.sv]
// checker: predicts intersection points for each accepted circle pair and compares the results
`timescale 1ns / 1ps

module cpip_points_checker (
   input  logic       clock,
   input  logic       reset,
   cpip_req_if        req,
   cpip_rsp_if        rsp,
   output int         mismatches,
   output int         awaiting
);
   import cpip_pkg::*;

   localparam int FRAC = 16;

   typedef struct {
      logic signed [PT_BITS-1:0] ax;
      logic signed [PT_BITS-1:0] ay;
      logic signed [PT_BITS-1:0] bx;
      logic signed [PT_BITS-1:0] by;
      status_type                status;
   } points_t;

   points_t expected_points[$];

   // offset n/(2t) rounded half away from zero, added to the shifted center
   function automatic logic [PT_BITS-1:0] place_coord(input logic signed [135:0] center,
                                                      input logic signed [135:0] n,
                                                      input logic signed [135:0] t);
      logic signed [135:0] nmag;
      logic signed [135:0] q;
      logic signed [135:0] v;
      nmag = (n < 0) ? -n : n;
      q = (nmag + t) / (2 * t);
      v = (n < 0) ? (center <<< FRAC) - q : (center <<< FRAC) + q;
      return v[PT_BITS-1:0];
   endfunction

   function automatic points_t predict_points(input logic signed [15:0] x1,
                                              input logic signed [15:0] y1,
                                              input logic [14:0] r1,
                                              input logic signed [15:0] x2,
                                              input logic signed [15:0] y2,
                                              input logic [14:0] r2);
      points_t             res;
      logic signed [16:0]  qx, qy;
      logic signed [135:0] qxw, qyw, tw, r1w, r2w, sum2, dif2, pw, mw, a2, rrw;
      logic signed [135:0] x2w, y2w;
      logic [127:0]        rad;
      logic [63:0]         rr, c;
      res = '{default: '0, status: STATUS_TWO};
      qx = x1 - x2;
      qy = y1 - y2;
      qxw = qx;
      qyw = qy;
      x2w = x2;
      y2w = y2;
      r1w = {121'b0, r1};
      r2w = {121'b0, r2};
      tw = qxw * qxw + qyw * qyw;
      sum2 = (r1w + r2w) * (r1w + r2w);
      dif2 = (r1w - r2w) * (r1w - r2w);
      if (tw == 0) begin
         res.status = STATUS_SAME;
         return res;
      end
      if (tw > sum2 || tw < dif2) begin
         res.status = STATUS_NONE;
         return res;
      end
      pw = sum2 - tw;
      mw = tw - dif2;
      res.status = (pw == 0 || mw == 0) ? STATUS_TANGENT : STATUS_TWO;
      // bitwise square root of the discriminant scaled by 2^(2*FRAC), so the root has FRAC fraction bits
      rad = 128'(pw * mw) << (2 * FRAC);
      rr = '0;
      for (int b = 63; b >= 0; b--) begin
         c = rr | (64'd1 << b);
         if (rad >= 128'(c) * 128'(c)) rr = c;
      end
      rrw = {72'b0, rr};
      a2 = tw + r2w * r2w - r1w * r1w;
      res.ax = place_coord(x2w, ((a2 * qxw) <<< FRAC) + qyw * rrw, tw);
      res.ay = place_coord(y2w, ((a2 * qyw) <<< FRAC) - qxw * rrw, tw);
      res.bx = place_coord(x2w, ((a2 * qxw) <<< FRAC) - qyw * rrw, tw);
      res.by = place_coord(y2w, ((a2 * qyw) <<< FRAC) + qxw * rrw, tw);
      return res;
   endfunction

   assign awaiting = expected_points.size();

   always @(posedge clock) begin
      points_t want;
      if (reset) begin
         mismatches <= 0;
      end else begin
         if (req.valid && req.ready)
            expected_points.push_back(predict_points(req.first_center_x,
               req.first_center_y, req.first_radius, req.second_center_x,
               req.second_center_y, req.second_radius));
         if (rsp.valid && rsp.ready) begin
            if (expected_points.size() == 0) begin
               if (mismatches < 10) $display("unexpected result transfer at %0t", $realtime);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_points.pop_front();
               if (rsp.point_a_x !== want.ax || rsp.point_a_y !== want.ay ||
                   rsp.point_b_x !== want.bx || rsp.point_b_y !== want.by ||
                   rsp.status !== want.status) begin
                  if (mismatches < 10)
                     $display("mismatch %0t: exp (%0d,%0d) (%0d,%0d) %0d, got (%0d,%0d) (%0d,%0d) %0d",
                        $realtime, want.ax, want.ay, want.bx, want.by, want.status,
                        rsp.point_a_x, rsp.point_a_y, rsp.point_b_x, rsp.point_b_y,
                        rsp.status);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

[test/circle_pair_intersection_points_top_tb.sv]
// testbench top: drives circle pairs through the block under several idle patterns
`timescale 1ns / 1ps

module circle_pair_intersection_points_top_tb;
   import cpip_pkg::*;

   localparam int LIMIT = 600000;   // generous, covers the slowest idle phase and the long hold

   logic clock;
   logic reset;
   int   mismatches;
   int   awaiting;
   int   cycles;
   int   send_idle_pct;   // chance in 100 that the sender skips a cycle
   int   stall_pct;       // chance in 100 that the receiver is not ready
   bit   long_hold_req;   // asks the receiver for one long hold-off
   bit   long_hold_done;
   int   hold_left;

   cpip_req_if #(.COORD_BITS(16)) req_ch (clock);
   cpip_rsp_if                    rsp_ch (clock);

   circle_pair_intersection_points_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   cpip_points_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on total cycles
   initial begin
      cycles = 0;
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // receiver side: random stalls, plus one long hold-off so the pipeline fills
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left = 0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !long_hold_done) begin
            hold_left = 400;
            long_hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // one transfer on the input channel, called at a falling edge
   task automatic offer_pair(input logic [15:0] x1, input logic [15:0] y1,
                             input logic [14:0] r1, input logic [15:0] x2,
                             input logic [15:0] y2, input logic [14:0] r2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.first_center_x  <= x1;
      req_ch.first_center_y  <= y1;
      req_ch.first_radius    <= r1;
      req_ch.second_center_x <= x2;
      req_ch.second_center_y <= y2;
      req_ch.second_radius   <= r2;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // random pair, mostly circles close enough to cross at a random scale
   task automatic offer_random_pair();
      int scale, x2, y2, dx, dy, k, r1, r2;
      int unsigned mode;
      mode = $urandom_range(9);
      if (mode == 0) begin
         // unconstrained noise, mostly disjoint circles
         offer_pair(16'($urandom), 16'($urandom), 15'($urandom),
                    16'($urandom), 16'($urandom), 15'($urandom));
      end else if (mode == 1) begin
         // tangent from a 3-4-5 triangle, outside or inside
         k = $urandom_range(1, 3000);
         x2 = $urandom_range(0, 40000) - 20000;
         y2 = $urandom_range(0, 40000) - 20000;
         r1 = $urandom_range(0, 5 * k);
         r2 = $urandom_range(0, 1) ? 5 * k - r1 : 5 * k + r1;
         if (r2 > 32767) r2 = 5 * k - r1;
         offer_pair(16'(x2 + 3 * k * ($urandom_range(0, 1) ? 1 : -1)),
                    16'(y2 + 4 * k * ($urandom_range(0, 1) ? 1 : -1)), 15'(r1),
                    16'(x2), 16'(y2), 15'(r2));
      end else begin
         case ($urandom_range(3))
            0: scale = 15;
            1: scale = 255;
            2: scale = 4095;
            default: scale = 32767;
         endcase
         x2 = $urandom_range(0, 65535) - 32768;
         y2 = $urandom_range(0, 65535) - 32768;
         dx = $urandom_range(0, 2 * scale) - scale;
         dy = $urandom_range(0, 2 * scale) - scale;
         if (x2 + dx > 32767 || x2 + dx < -32768) dx = -dx;
         if (y2 + dy > 32767 || y2 + dy < -32768) dy = -dy;
         r1 = $urandom_range(0, scale);
         r2 = $urandom_range(0, scale);
         offer_pair(16'(x2 + dx), 16'(y2 + dy), 15'(r1), 16'(x2), 16'(y2), 15'(r2));
      end
   endtask

   initial begin
      req_ch.valid           = 1'b0;
      req_ch.first_center_x  = '0;
      req_ch.first_center_y  = '0;
      req_ch.first_radius    = '0;
      req_ch.second_center_x = '0;
      req_ch.second_center_y = '0;
      req_ch.second_radius   = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      long_hold_req = 1'b0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes and every status
      offer_pair(16'sd3, 16'sd4, 15'd5, 16'sd0, 16'sd0, 15'd5);            // two points
      offer_pair(16'sd10, 16'sd0, 15'd5, 16'sd0, 16'sd0, 15'd5);           // outside tangent
      offer_pair(16'sd3, 16'sd4, 15'd5, 16'sd0, 16'sd0, 15'd10);           // inside tangent
      offer_pair(16'sd100, 16'sd0, 15'd5, 16'sd0, 16'sd0, 15'd5);          // apart
      offer_pair(16'sd1, 16'sd0, 15'd1, 16'sd0, 16'sd0, 15'd30);           // one inside other
      offer_pair(16'sd7, -16'sd7, 15'd3, 16'sd7, -16'sd7, 15'd9);          // same center
      offer_pair(16'sd0, 16'sd0, 15'd0, 16'sd0, 16'sd0, 15'd0);            // same center, zero radii
      offer_pair(16'sd5, 16'sd0, 15'd0, 16'sd0, 16'sd0, 15'd5);            // zero radius on circle
      offer_pair(16'sd5, 16'sd0, 15'd5, 16'sd0, 16'sd0, 15'd0);
      offer_pair(16'sh7fff, 16'sh7fff, 15'h7fff, 16'sh8000, 16'sh8000, 15'h7fff);
      offer_pair(16'sh8000, 16'sh8000, 15'h7fff, 16'sh7fff, 16'sh7fff, 15'h7fff);
      offer_pair(16'sh7fff, 16'sh8000, 15'h7fff, 16'sh8000, 16'sh7fff, 15'h7fff);
      offer_pair(16'sh7fff, 16'sh0000, 15'h7fff, 16'sh8000, 16'sh0000, 15'h7fff);
      offer_pair(16'sh0000, 16'sh7fff, 15'h7fff, 16'sh0000, 16'sh8000, 15'h7fff);
      offer_pair(16'sh7fff, 16'sh7fff, 15'd1, 16'sh7ffe, 16'sh7fff, 15'd1);
      offer_pair(16'sh8000, 16'sh8000, 15'h7fff, 16'sh8001, 16'sh8000, 15'h7ffe);
      offer_pair(-16'sd4, 16'sd3, 15'd4, 16'sd0, 16'sd0, 15'd3);
      offer_pair(16'sd1, 16'sd1, 15'd1, 16'sd0, 16'sd0, 15'd1);

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 81; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 81; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
         endcase
         for (int i = 0; i < 375; i++) begin
            if (ph == 0 && i == 100) long_hold_req = 1'b1;
            offer_random_pair();
         end
      end
      req_ch.valid <= 1'b0;
      stall_pct = 0;

      // drain, then let the pipeline settle past its latency
      while (awaiting != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (mismatches == 0 && awaiting == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
